// ===== src/imh_pkg.sv =====
`default_nettype none
package imh_pkg;
    localparam int HeapCapacity = 256;
    localparam int KeySpace = 256;
    localparam int KeyW = 8;
    localparam int CountW = 32;
    localparam int SlotW = 9;
    localparam int AddrW = 8;
    localparam int EntryW = CountW + KeyW;

    typedef struct packed {
        logic [KeyW-1:0]   key;
        logic [CountW-1:0] amount;
    } in_word_t;

    typedef struct packed {
        logic [KeyW-1:0]   top_key;
        logic [CountW-1:0] top_count;
        logic [SlotW-1:0]  entry_count;
        logic              dropped;
    } out_word_t;

    typedef struct packed {
        logic [CountW-1:0] count;
        logic [KeyW-1:0]   key;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_READ_SELF,
        ST_UP_READ,
        ST_UP_CMP,
        ST_DN_READ_L,
        ST_DN_READ_R,
        ST_DN_CMP,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_TOP_READ,
        ST_TOP_WAIT,
        ST_DONE
    } state_t;

    // strict heap order: lower count, then lower key
    function automatic logic beats(entry_t a, entry_t b);
        logic r;
        r = (a.count < b.count) || ((a.count == b.count) && (a.key < b.key));
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== src/imh_ram.sv =====
`default_nettype none
module imh_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== src/imh_pos_table.sv =====
`default_nettype none
// key to slot table; entries without a valid bit read as absent
module imh_pos_table (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      we,
    input  wire logic [imh_pkg::KeyW-1:0]  waddr,
    input  wire logic [imh_pkg::SlotW-1:0] wdata,
    input  wire logic [imh_pkg::KeyW-1:0]  raddr,
    output logic      [imh_pkg::SlotW-1:0] rdata
);
    import imh_pkg::*;

    logic [KeySpace-1:0] valid_reg;
    logic                rvalid_reg;
    logic [SlotW-1:0]    ram_rdata;

    imh_ram #(.Width(SlotW), .Depth(KeySpace)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rvalid_reg ? ram_rdata : '0;
endmodule
`default_nettype wire

// ===== src/indexed_min_heap_add_key_core.sv =====
`default_nettype none
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_ready  | in_word_t  (key, amount)
// out     | out | out_valid/out_ready| out_word_t (top_key, top_count, entry_count, dropped)
//
// one word at a time; a new key climbs from the new last slot and an update
// descends from its own slot, at most 8 levels either way, the work paced by the
// single heap memory port pair (one read, one write per cycle) and the shared compare.
// reset clears the fill level and the key valid bits at once; no sweep.
// a finished result waits in ST_DONE until the output register is free;
// in_ready returns the cycle after it is loaded.
module indexed_min_heap_add_key_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire imh_pkg::in_word_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output imh_pkg::out_word_t      out_data
);
    import imh_pkg::*;

    state_t state_reg, state_next;

    // working registers
    logic [KeyW-1:0]   key_reg;
    logic [CountW-1:0] amount_reg;
    logic [SlotW-1:0]  fill_reg, fill_next;
    logic [SlotW-1:0]  cur_reg, cur_next;      // slot of the moving entry
    logic [SlotW-1:0]  oth_reg, oth_next;      // slot it trades with
    entry_t            self_reg, self_next;    // moving entry
    entry_t            oth_e_reg, oth_e_next;  // best partner so far
    logic              dropped_reg, dropped_next;
    logic              up_reg, up_next;        // sifting up vs down
    out_word_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    // heap memory, slot s held at address s-1
    logic             h_we;
    logic [AddrW-1:0] h_waddr, h_raddr;
    entry_t           h_wdata, h_rdata;

    imh_ram #(.Width(EntryW), .Depth(HeapCapacity)) u_heap (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    logic             p_we;
    logic [KeyW-1:0]  p_waddr;
    logic [KeyW-1:0]  p_raddr;
    logic [SlotW-1:0] p_wdata, p_rdata;

    // look the key up at the accepting edge so the slot is ready in ST_LOOKUP
    assign p_raddr = (state_reg == ST_IDLE) ? in_data.key : key_reg;

    imh_pos_table u_pos (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    // shared compare and saturating add
    entry_t            cmp_a, cmp_b;
    logic              cmp_win;
    logic [CountW:0]   sum_w;
    logic [CountW-1:0] sum_sat;
    logic [SlotW:0]    left_w;

    assign cmp_win = beats(cmp_a, cmp_b);
    assign sum_w   = {1'b0, h_rdata.count} + {1'b0, amount_reg};
    assign sum_sat = sum_w[CountW] ? '1 : sum_w[CountW-1:0];
    assign left_w  = {cur_reg, 1'b0};

    function automatic logic [AddrW-1:0] slot_addr(logic [SlotW-1:0] s);
        logic [SlotW-1:0] a;
        a = s - SlotW'(1);
        return a[AddrW-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= (state_reg == ST_IDLE) ? in_data.key : key_reg;
        amount_reg  <= (state_reg == ST_IDLE) ? in_data.amount : amount_reg;
        cur_reg     <= cur_next;
        oth_reg     <= oth_next;
        self_reg    <= self_next;
        oth_e_reg   <= oth_e_next;
        dropped_reg <= dropped_next;
        up_reg      <= up_next;
        out_reg     <= out_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (p_rdata == '0 || p_rdata > fill_reg)
                begin
                    if (fill_reg == SlotW'(HeapCapacity))
                    begin
                        state_next = ST_TOP_READ;
                    end
                    else if (fill_reg == '0)
                    begin
                        state_next = ST_TOP_READ;
                    end
                    else
                    begin
                        state_next = ST_UP_READ;
                    end
                end
                else
                begin
                    state_next = ST_READ_SELF;
                end
            end
            ST_READ_SELF: state_next = ST_DN_READ_L;
            ST_UP_READ:   state_next = ST_UP_CMP;
            ST_UP_CMP:    state_next = cmp_win ? ST_SWAP_A : ST_TOP_READ;
            ST_DN_READ_L:
            begin
                if (left_w > {1'b0, fill_reg})
                begin
                    state_next = ST_TOP_READ;
                end
                else
                begin
                    state_next = ST_DN_READ_R;
                end
            end
            ST_DN_READ_R: state_next = ST_DN_CMP;
            ST_DN_CMP:    state_next = ST_SWAP_A;
            ST_SWAP_A:
            begin
                if (oth_reg == cur_reg)
                begin
                    state_next = ST_TOP_READ;
                end
                else
                begin
                    state_next = ST_SWAP_B;
                end
            end
            ST_SWAP_B:
            begin
                if (up_reg)
                begin
                    state_next = (oth_reg == SlotW'(1)) ? ST_TOP_READ : ST_UP_READ;
                end
                else
                begin
                    state_next = ST_DN_READ_L;
                end
            end
            ST_TOP_READ:  state_next = ST_TOP_WAIT;
            ST_TOP_WAIT:  state_next = ST_DONE;
            ST_DONE:      state_next = (!out_valid_reg || out_ready) ? ST_IDLE : ST_DONE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        fill_next      = fill_reg;
        cur_next       = cur_reg;
        oth_next       = oth_reg;
        self_next      = self_reg;
        oth_e_next     = oth_e_reg;
        dropped_next   = dropped_reg;
        up_next        = up_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        h_we           = 1'b0;
        h_waddr        = slot_addr(cur_reg);
        h_wdata        = self_reg;
        h_raddr        = slot_addr(cur_reg);
        p_we           = 1'b0;
        p_waddr        = self_reg.key;
        p_wdata        = cur_reg;
        cmp_a          = self_reg;
        cmp_b          = oth_e_reg;
        case (state_reg)
            ST_IDLE:
            begin
                dropped_next = 1'b0;
            end
            ST_LOOKUP:
            begin
                if (p_rdata == '0 || p_rdata > fill_reg)
                begin
                    if (fill_reg == SlotW'(HeapCapacity))
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        // append at the new last slot
                        fill_next      = fill_reg + SlotW'(1);
                        cur_next       = fill_reg + SlotW'(1);
                        self_next      = '{count: amount_reg, key: key_reg};
                        up_next        = 1'b1;
                        h_we           = 1'b1;
                        h_waddr        = slot_addr(fill_reg + SlotW'(1));
                        h_wdata        = '{count: amount_reg, key: key_reg};
                        p_we           = 1'b1;
                        p_waddr        = key_reg;
                        p_wdata        = fill_reg + SlotW'(1);
                    end
                end
                else
                begin
                    cur_next = p_rdata;
                    up_next  = 1'b0;
                    h_raddr  = slot_addr(p_rdata);
                end
            end
            ST_READ_SELF:
            begin
                self_next = '{count: sum_sat, key: key_reg};
                h_we      = 1'b1;
                h_wdata   = '{count: sum_sat, key: key_reg};
            end
            ST_UP_READ:
            begin
                oth_next = cur_reg >> 1;
                h_raddr  = slot_addr(cur_reg >> 1);
            end
            ST_UP_CMP:
            begin
                oth_e_next = h_rdata;
                cmp_b      = h_rdata;
            end
            ST_DN_READ_L:
            begin
                oth_next   = cur_reg;
                oth_e_next = self_reg;
                h_raddr    = slot_addr(left_w[SlotW-1:0]);
            end
            ST_DN_READ_R:
            begin
                // left child result arrives now
                cmp_a = h_rdata;
                cmp_b = self_reg;
                if (cmp_win)
                begin
                    oth_next   = left_w[SlotW-1:0];
                    oth_e_next = h_rdata;
                end
                h_raddr = slot_addr(left_w[SlotW-1:0] + SlotW'(1));
            end
            ST_DN_CMP:
            begin
                cmp_a = h_rdata;
                cmp_b = oth_e_reg;
                if ((left_w + (SlotW+1)'(1)) <= {1'b0, fill_reg} && cmp_win)
                begin
                    oth_next   = left_w[SlotW-1:0] + SlotW'(1);
                    oth_e_next = h_rdata;
                end
            end
            ST_SWAP_A:
            begin
                if (oth_reg != cur_reg)
                begin
                    // partner moves into the current slot
                    h_we    = 1'b1;
                    h_waddr = slot_addr(cur_reg);
                    h_wdata = oth_e_reg;
                    p_we    = 1'b1;
                    p_waddr = oth_e_reg.key;
                    p_wdata = cur_reg;
                end
            end
            ST_SWAP_B:
            begin
                h_we     = 1'b1;
                h_waddr  = slot_addr(oth_reg);
                h_wdata  = self_reg;
                p_we     = 1'b1;
                p_waddr  = self_reg.key;
                p_wdata  = oth_reg;
                cur_next = oth_reg;
            end
            ST_TOP_READ:
            begin
                h_raddr = slot_addr(SlotW'(1));
            end
            ST_TOP_WAIT:
            begin
                // keep the root on the read port until the result is loaded
                h_raddr = slot_addr(SlotW'(1));
            end
            ST_DONE:
            begin
                h_raddr = slot_addr(SlotW'(1));
                // load only once the previous result has left
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next       = 1'b1;
                    out_next.entry_count = fill_reg;
                    out_next.dropped     = dropped_reg;
                    out_next.top_key     = (fill_reg == '0) ? '0 : h_rdata.key;
                    out_next.top_count   = (fill_reg == '0) ? '0 : h_rdata.count;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule
`default_nettype wire

// ===== src/imh_checker.sv =====
`default_nettype none
module imh_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire imh_pkg::in_word_t  in_data,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire imh_pkg::out_word_t out_data
);
    import imh_pkg::*;

    // no new word while busy with one
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("accepted a word while busy");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result changed while stalled");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.entry_count == '0) |->
            (out_data.top_count == '0 && out_data.top_key == '0))
        else $error("empty heap reports a top");

    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.dropped) |->
            (out_data.entry_count == SlotW'(HeapCapacity)))
        else $error("drop with room left");
endmodule

bind indexed_min_heap_add_key_core imh_checker u_imh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire
